// File: sv/est_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the encoder setpoint thermostat
// no dependencies; used by est_cfg, est_core and the top level

package est_pkg;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_BUTTON = 2'd1,
        CMD_ENC    = 2'd2,
        CMD_TEMP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_RUN    = 2'd0,
        MODE_TARGET = 2'd1,
        MODE_PAUSE  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_TARGET_MIN   = 3'd0,
        REG_TARGET_MAX   = 3'd1,
        REG_LOCKOUT_MS   = 3'd2,
        REG_FAST_TURN_MS = 3'd3,
        REG_BOUNCE_MS    = 3'd4,
        REG_MAX_STEP     = 3'd5
    } reg_index_t;

    localparam int CFG_DATA_W = 16;

    localparam logic signed [7:0] TARGET_MIN_RST = -8'sd99;
    localparam logic signed [7:0] TARGET_MAX_RST = 8'sd50;
    localparam logic [15:0]       LOCKOUT_RST    = 16'd300;
    localparam logic [15:0]       FAST_TURN_RST  = 16'd150;
    localparam logic [15:0]       BOUNCE_RST     = 16'd5;
    localparam logic [3:0]        MAX_STEP_RST   = 4'd8;
    localparam logic signed [7:0] TARGET_RST     = -8'sd20;

    typedef struct packed {
        logic signed [7:0] target_min;
        logic signed [7:0] target_max;
        logic [15:0]       button_lockout_ms;
        logic [15:0]       fast_turn_ms;
        logic [15:0]       bounce_floor_ms;
        logic [3:0]        max_step;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               enc_a;
        logic               enc_b;
        logic signed [11:0] temp_sample;
        logic               sensor_present;
    } item_t;

    typedef struct packed {
        logic              cooler_on;
        logic              pump_on;
        logic [1:0]        menu_mode;
        logic signed [7:0] target_now;
        logic              paused_now;
        logic              save_request;
    } result_t;

endpackage

// File: sv/est_cfg.sv
`timescale 1ns / 1ps
// configuration register file with reset values
// depends on est_pkg

module est_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [est_pkg::CFG_DATA_W-1:0] cfg_data,
    output est_pkg::cfg_t                  cfg
);

    est_pkg::cfg_t cfg_reg;
    est_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                est_pkg::REG_TARGET_MIN:   cfg_next.target_min        = cfg_data[7:0];
                est_pkg::REG_TARGET_MAX:   cfg_next.target_max        = cfg_data[7:0];
                est_pkg::REG_LOCKOUT_MS:   cfg_next.button_lockout_ms = cfg_data;
                est_pkg::REG_FAST_TURN_MS: cfg_next.fast_turn_ms      = cfg_data;
                est_pkg::REG_BOUNCE_MS:    cfg_next.bounce_floor_ms   = cfg_data;
                est_pkg::REG_MAX_STEP:     cfg_next.max_step          = cfg_data[3:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_min        <= est_pkg::TARGET_MIN_RST;
            cfg_reg.target_max        <= est_pkg::TARGET_MAX_RST;
            cfg_reg.button_lockout_ms <= est_pkg::LOCKOUT_RST;
            cfg_reg.fast_turn_ms      <= est_pkg::FAST_TURN_RST;
            cfg_reg.bounce_floor_ms   <= est_pkg::BOUNCE_RST;
            cfg_reg.max_step          <= est_pkg::MAX_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/est_core.sv
`timescale 1ns / 1ps
// event state machine: timers, menu, encoder stepping, relays
// depends on est_pkg; result is combinational from the next state

module est_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  est_pkg::item_t   item,
    input  est_pkg::cfg_t    cfg,
    output est_pkg::result_t result
);

    logic [31:0]        now_reg, now_next;
    logic [31:0]        last_press_reg, last_press_next;
    logic [31:0]        last_turn_reg, last_turn_next;
    logic               prev_a_reg, prev_a_next;
    logic               prev_dir_reg, prev_dir_next;
    logic [3:0]         step_reg, step_next;
    est_pkg::mode_t     mode_reg, mode_next;
    logic signed [7:0]  target_reg, target_next;
    logic               paused_reg, paused_next;
    logic               changed_reg, changed_next;
    logic signed [11:0] temp_reg, temp_next;
    logic               sensor_reg, sensor_next;
    logic               cooler_reg, cooler_next;
    logic               pump_reg, pump_next;
    logic               save;

    logic [31:0]        press_elapsed;
    logic [31:0]        turn_elapsed;
    logic               dir;
    logic signed [9:0]  tgt_ext, step_ext, tgt_sum, min_ext, max_ext;
    logic signed [7:0]  tgt_clamped;
    logic signed [5:0]  pause_sum;
    logic               pause_clamped;
    logic [3:0]         step_rev, step_enc;
    logic signed [11:0] target_x16;

    assign press_elapsed = now_reg - last_press_reg;
    assign turn_elapsed  = now_reg - last_turn_reg;
    assign dir           = (item.enc_b == item.enc_a);

    // accelerating value step and clamp
    assign tgt_ext  = {{2{target_reg[7]}}, target_reg};
    assign step_ext = {6'd0, step_reg};
    assign min_ext  = {{2{cfg.target_min[7]}}, cfg.target_min};
    assign max_ext  = {{2{cfg.target_max[7]}}, cfg.target_max};
    assign tgt_sum  = dir ? (tgt_ext - step_ext) : (tgt_ext + step_ext);
    assign tgt_clamped = (tgt_sum < min_ext) ? cfg.target_min :
                         (tgt_sum > max_ext) ? cfg.target_max : tgt_sum[7:0];

    assign pause_sum = dir ? ({5'd0, paused_reg} - {2'd0, step_reg})
                           : ({5'd0, paused_reg} + {2'd0, step_reg});
    assign pause_clamped = (pause_sum > 6'sd0);

    assign step_rev = (dir != prev_dir_reg) ? 4'd1 : step_reg;
    assign step_enc = (turn_elapsed < {16'd0, cfg.fast_turn_ms}) ?
                      (((turn_elapsed > {16'd0, cfg.bounce_floor_ms}) &&
                        (step_rev < cfg.max_step)) ? step_rev + 4'd1 : step_rev) :
                      4'd1;

    always_comb
    begin
        now_next        = now_reg;
        last_press_next = last_press_reg;
        last_turn_next  = last_turn_reg;
        prev_a_next     = prev_a_reg;
        prev_dir_next   = prev_dir_reg;
        step_next       = step_reg;
        mode_next       = mode_reg;
        target_next     = target_reg;
        paused_next     = paused_reg;
        changed_next    = changed_reg;
        temp_next       = temp_reg;
        sensor_next     = sensor_reg;
        save            = 1'b0;

        unique case (item.cmd)
            est_pkg::CMD_TICK:
            begin
                now_next = now_reg + 32'd1;
            end
            est_pkg::CMD_BUTTON:
            begin
                if (press_elapsed > {16'd0, cfg.button_lockout_ms})
                begin
                    last_press_next = now_reg;
                    unique case (mode_reg)
                        est_pkg::MODE_RUN:
                        begin
                            mode_next    = est_pkg::MODE_TARGET;
                            changed_next = 1'b0;
                        end
                        est_pkg::MODE_TARGET:
                        begin
                            mode_next = est_pkg::MODE_PAUSE;
                        end
                        est_pkg::MODE_PAUSE:
                        begin
                            mode_next = est_pkg::MODE_RUN;
                            save      = changed_reg;
                        end
                        default:
                        begin
                            mode_next = est_pkg::MODE_RUN;
                        end
                    endcase
                end
            end
            est_pkg::CMD_ENC:
            begin
                if (item.enc_a != prev_a_reg)
                begin
                    prev_a_next = item.enc_a;
                    if (mode_reg != est_pkg::MODE_RUN)
                    begin
                        if (mode_reg == est_pkg::MODE_TARGET)
                        begin
                            target_next = tgt_clamped;
                        end
                        else
                        begin
                            paused_next = pause_clamped;
                        end
                        changed_next   = 1'b1;
                        prev_dir_next  = dir;
                        last_turn_next = now_reg;
                        step_next      = step_enc;
                    end
                end
            end
            est_pkg::CMD_TEMP:
            begin
                sensor_next = item.sensor_present;
                if (item.sensor_present)
                begin
                    temp_next = item.temp_sample;
                end
            end
            default:
            begin
                now_next = now_reg;
            end
        endcase
    end

    // relays follow only in run mode
    assign target_x16 = {target_next, 4'd0};

    always_comb
    begin
        cooler_next = cooler_reg;
        pump_next   = pump_reg;
        if (mode_next == est_pkg::MODE_RUN)
        begin
            if (paused_next)
            begin
                pump_next   = 1'b0;
                cooler_next = 1'b0;
            end
            else
            begin
                pump_next   = 1'b1;
                cooler_next = sensor_next && (temp_next > target_x16);
            end
        end
    end

    always_comb
    begin
        result.cooler_on    = cooler_next;
        result.pump_on      = pump_next;
        result.menu_mode    = mode_next;
        result.target_now   = target_next;
        result.paused_now   = paused_next;
        result.save_request = save;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= 32'd0;
            last_press_reg <= 32'd0;
            last_turn_reg  <= 32'd0;
            prev_a_reg     <= 1'b0;
            prev_dir_reg   <= 1'b0;
            step_reg       <= 4'd1;
            mode_reg       <= est_pkg::MODE_RUN;
            target_reg     <= est_pkg::TARGET_RST;
            paused_reg     <= 1'b0;
            changed_reg    <= 1'b0;
            temp_reg       <= 12'sd0;
            sensor_reg     <= 1'b0;
            cooler_reg     <= 1'b0;
            pump_reg       <= 1'b1;
        end
        else if (fire)
        begin
            now_reg        <= now_next;
            last_press_reg <= last_press_next;
            last_turn_reg  <= last_turn_next;
            prev_a_reg     <= prev_a_next;
            prev_dir_reg   <= prev_dir_next;
            step_reg       <= step_next;
            mode_reg       <= mode_next;
            target_reg     <= target_next;
            paused_reg     <= paused_next;
            changed_reg    <= changed_next;
            temp_reg       <= temp_next;
            sensor_reg     <= sensor_next;
            cooler_reg     <= cooler_next;
            pump_reg       <= pump_next;
        end
    end

endmodule

// File: sv/encoder_setpoint_thermostat.sv
`timescale 1ns / 1ps
// top level: input register, event core, result register
// depends on est_pkg, est_cfg and est_core
// each input is held in item_reg, and its result is registered in result_reg when it fires
// throughput: one event per cycle while the result side is not stalled
// reset: valid flags, core state and configuration take their reset values at once;
// the block accepts events in the first cycle after reset

module encoder_setpoint_thermostat
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic                           enc_a,
    input  logic                           enc_b,
    input  logic signed [11:0]             temp_sample,
    input  logic                           sensor_present,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           cooler_on,
    output logic                           pump_on,
    output logic [1:0]                     menu_mode,
    output logic signed [7:0]              target_now,
    output logic                           paused_now,
    output logic                           save_request,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [est_pkg::CFG_DATA_W-1:0] cfg_data
);

    est_pkg::cfg_t    cfg;
    est_pkg::item_t   item_reg;
    est_pkg::result_t result;
    est_pkg::result_t result_reg;
    logic             item_valid_reg, item_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             in_take;
    logic             fire;

    est_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    est_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = item_valid_reg && out_free;
    assign in_stall = item_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign item_valid_next = in_take || (item_valid_reg && !fire);
    assign out_valid_next  = fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.cmd            <= cmd;
            item_reg.enc_a          <= enc_a;
            item_reg.enc_b          <= enc_b;
            item_reg.temp_sample    <= temp_sample;
            item_reg.sensor_present <= sensor_present;
        end
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cooler_on    = result_reg.cooler_on;
    assign pump_on      = result_reg.pump_on;
    assign menu_mode    = result_reg.menu_mode;
    assign target_now   = result_reg.target_now;
    assign paused_now   = result_reg.paused_now;
    assign save_request = result_reg.save_request;

endmodule
